>>> sv/oslr_pkg.sv
// ----------------------------------------------------------------------------
// oslr_pkg - shared types and constants for the sample log ring
// Command codes, register indexes, FSM state type, control/status bundles and
// the fixed-point constants used by the datapath.
// ----------------------------------------------------------------------------
package oslr_pkg;

    // Default log depth (records)
    localparam int DEF_DEPTH = 256;

    // Command codes carried on cmd
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_PULL   = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;
    localparam logic [1:0] CMD_STATUS = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] CFG_UNIT_MODE   = 2'd0;
    localparam logic [1:0] CFG_INTERVAL_MS = 2'd1;

    // Temperature unit codes
    localparam logic [1:0] UNIT_KELVIN  = 2'd0;
    localparam logic [1:0] UNIT_CELSIUS = 2'd1;

    // Reset values of the configuration registers
    localparam logic [1:0]  UNIT_RESET     = UNIT_KELVIN;
    localparam logic [31:0] INTERVAL_RESET = 32'd1000;

    // Temperature offsets in hundredths
    localparam logic [31:0] KELVIN_OFS  = 32'd22315;
    localparam logic [31:0] CELSIUS_OFS = 32'd5000;

    // Record layout
    localparam int TIME_W = 17;
    localparam int TEMP_W = 32 - TIME_W;

    // interval / 1000 = (interval >> 3) / 125; the divide by 125 is a
    // multiply by ceil(2^36 / 125) and a shift by 36 (exact for 29-bit input)
    localparam int          DIV_PRE_SHIFT = 3;
    localparam int          DIV_IN_W      = 32 - DIV_PRE_SHIFT;
    localparam int          RECIP_W       = 30;
    localparam logic [29:0] RECIP_125     = 30'd549755814;
    localparam int          RECIP_SHIFT   = 36;
    localparam int          DIV_PROD_W    = DIV_IN_W + RECIP_W;
    localparam int          QUOT_W        = 23;

    // Index of the last byte of a result run
    localparam logic [2:0] LAST_BYTE_IDX = 3'd7;

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_DIV,
        ST_MUL,
        ST_SEND
    } state_t;

    // Controller to datapath commands
    typedef struct packed {
        logic push;       // store record, advance write side
        logic pull;       // read oldest entry, advance read side
        logic clear;      // empty the log
        logic load_pull;  // load pull words from read data
        logic div_step;   // register interval / 1000
        logic load_stat;  // load status words
        logic shift_out;  // a byte transaction completed
    } ctrl_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic empty;
    } dp_stat_t;

endpackage

>>> sv/oslr_ctrl.sv
// ----------------------------------------------------------------------------
// oslr_ctrl - command sequencer for the sample log ring
// Decodes accepted commands, steps the read and arithmetic cycles and counts
// the eight output bytes of a run.
// ----------------------------------------------------------------------------
module oslr_ctrl (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             cmd,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   last_byte,
    input  oslr_pkg::dp_stat_t     stat,
    output oslr_pkg::ctrl_cmd_t    ctl
);
    import oslr_pkg::*;

    state_t     state_reg;
    state_t     state_next;
    logic [2:0] byte_cnt_reg;
    logic [2:0] byte_cnt_next;
    logic       in_take;
    logic       out_take;

    assign in_take  = in_valid && (state_reg == ST_IDLE);
    assign out_take = (state_reg == ST_SEND) && !out_stall;

    // State and byte counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            byte_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            byte_cnt_reg <= byte_cnt_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next    = state_reg;
        byte_cnt_next = byte_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                byte_cnt_next = '0;
                if (in_take)
                begin
                    if (cmd == CMD_PULL && !stat.empty)
                        state_next = ST_READ;
                    else if (cmd == CMD_STATUS)
                        state_next = ST_DIV;
                end
            end
            ST_READ: state_next = ST_SEND;
            ST_DIV:  state_next = ST_MUL;
            ST_MUL:  state_next = ST_SEND;
            ST_SEND:
            begin
                if (out_take)
                begin
                    byte_cnt_next = byte_cnt_reg + 3'd1;
                    if (byte_cnt_reg == LAST_BYTE_IDX)
                        state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath commands
    always_comb
    begin
        ctl           = '0;
        in_stall      = (state_reg != ST_IDLE);
        out_valid     = (state_reg == ST_SEND);
        last_byte     = (byte_cnt_reg == LAST_BYTE_IDX);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_take)
                begin
                    ctl.push  = (cmd == CMD_PUSH);
                    ctl.pull  = (cmd == CMD_PULL) && !stat.empty;
                    ctl.clear = (cmd == CMD_CLEAR);
                end
            end
            ST_READ: ctl.load_pull = 1'b1;
            ST_DIV:  ctl.div_step  = 1'b1;
            ST_MUL:  ctl.load_stat = 1'b1;
            ST_SEND: ctl.shift_out = out_take;
            default: ctl = '0;
        endcase
    end

endmodule

>>> sv/oslr_dp.sv
// ----------------------------------------------------------------------------
// oslr_dp - datapath of the sample log ring
// Record memory, ring pointers, fill count, configuration registers, unit
// conversion, status arithmetic and the byte serializer.
// ----------------------------------------------------------------------------
module oslr_dp #(
    parameter int DEPTH = oslr_pkg::DEF_DEPTH
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [31:0]            record,
    input  logic                   cfg_valid,
    input  logic [1:0]             cfg_index,
    input  logic [31:0]            cfg_data,
    input  oslr_pkg::ctrl_cmd_t    ctl,
    output oslr_pkg::dp_stat_t     stat,
    output logic [7:0]             data_byte,
    output logic [8:0]             records_held
);
    import oslr_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    logic [31:0]   store_reg [DEPTH];
    logic [31:0]   rdata_reg;
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic [PW-1:0] wr_ptr_inc;
    logic [PW-1:0] rd_ptr_inc;
    logic [1:0]    unit_reg;
    logic [31:0]   interval_reg;
    logic [QUOT_W-1:0] quot_reg;
    logic [63:0]   shift_reg;
    logic [31:0]   temp_word;
    logic [31:0]   time_word;
    logic [31:0]   temp_raw;
    logic [DIV_PROD_W-1:0] div_prod;
    logic [31:0]   remain_word;
    logic [31:0]   total_word;

    // Pointer increment with wrap
    assign wr_ptr_inc = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PW'(1);
    assign rd_ptr_inc = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PW'(1);

    assign stat.empty = (count_reg == '0);

    // Ring pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (ctl.clear)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else if (ctl.push)
        begin
            wr_ptr_reg <= wr_ptr_inc;
            if (count_reg != CNT_FULL)
                count_reg <= count_reg + CW'(1);
            else
                rd_ptr_reg <= rd_ptr_inc;   // full: drop the oldest
        end
        else if (ctl.pull)
        begin
            rd_ptr_reg <= rd_ptr_inc;
            count_reg  <= count_reg - CW'(1);
        end
    end

    // Record memory, registered read
    always_ff @(posedge clk)
    begin
        if (ctl.push)
            store_reg[wr_ptr_reg] <= record;
        if (ctl.pull)
            rdata_reg <= store_reg[rd_ptr_reg];
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg     <= UNIT_RESET;
            interval_reg <= INTERVAL_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_UNIT_MODE:   unit_reg     <= cfg_data[1:0];
                CFG_INTERVAL_MS: interval_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // Unit conversion of the pulled record
    assign temp_raw  = 32'(rdata_reg[31:TIME_W]);
    assign time_word = 32'(rdata_reg[TIME_W-1:0]);
    always_comb
    begin
        case (unit_reg)
            UNIT_KELVIN:  temp_word = temp_raw + KELVIN_OFS;
            UNIT_CELSIUS: temp_word = temp_raw - CELSIUS_OFS;
            default:      temp_word = temp_raw;
        endcase
    end

    // interval / 1000 by reciprocal multiply
    assign div_prod = DIV_PROD_W'(interval_reg[31:DIV_PRE_SHIFT])
                    * DIV_PROD_W'(RECIP_125);
    always_ff @(posedge clk)
    begin
        if (ctl.div_step)
            quot_reg <= div_prod[RECIP_SHIFT +: QUOT_W];
    end

    // Remaining time: (DEPTH - count) * quotient, wrapped to 32 bits
    assign remain_word = 32'(CNT_FULL - count_reg);
    assign total_word  = remain_word * 32'(quot_reg);

    // Byte serializer, least significant byte first
    always_ff @(posedge clk)
    begin
        if (ctl.load_pull)
            shift_reg <= {time_word, temp_word};
        else if (ctl.load_stat)
            shift_reg <= {total_word, 32'(count_reg)};
        else if (ctl.shift_out)
            shift_reg <= {8'd0, shift_reg[63:8]};
    end

    assign data_byte    = shift_reg[7:0];
    assign records_held = 9'(count_reg);

endmodule

>>> sv/overwriting_sample_log_ring_core.sv
// ----------------------------------------------------------------------------
// overwriting_sample_log_ring_core - overwriting ring log of sample records
// Push stores a record (dropping the oldest when full), pull sends the oldest
// as eight bytes, status sends the count and the remaining sampling time.
//
//   channel   handshake              payload
//   input     in_valid / in_stall    cmd, record
//   output    out_valid / out_stall  data_byte, last_byte, records_held
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Push and clear are taken back to back. Pull passes through a memory read
// state, status through a divide and a multiply state, then eight bytes are
// sent; no new command is taken until the last byte transaction completes.
// Output stalls extend the byte phase.
// Reset clears pointers and count; the record memory is not cleared.
// ----------------------------------------------------------------------------
module overwriting_sample_log_ring_core #(
    parameter int DEPTH = oslr_pkg::DEF_DEPTH
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  cmd,
    input  logic [31:0] record,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  data_byte,
    output logic        last_byte,
    output logic [8:0]  records_held,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data
);
    import oslr_pkg::*;

    ctrl_cmd_t ctl;
    dp_stat_t  stat;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    oslr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .last_byte (last_byte),
        .stat      (stat),
        .ctl       (ctl)
    );

    oslr_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .record       (record),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .ctl          (ctl),
        .stat         (stat),
        .data_byte    (data_byte),
        .records_held (records_held)
    );

endmodule

>>> dv/overwriting_sample_log_ring_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// overwriting_sample_log_ring_core_test - self-checking bench for the log ring
// Drives push, pull, clear and status commands with random idle cycles on the
// command side and random stalls on the byte side. A shadow copy of the ring
// predicts every output byte. The bench steps through the unit modes and a
// range of sampling intervals, and runs one long burst of commands with no
// idle or stall cycles at all.
// ----------------------------------------------------------------------------
module overwriting_sample_log_ring_core_test;
    import oslr_pkg::*;

    localparam int          LOG_DEPTH    = DEF_DEPTH;
    localparam int          LIMIT_CYCLES = 200000;
    localparam int          SETTLE_CYC   = 16;
    localparam int          MIX_ITEMS    = 13;
    localparam int          BURST_PUSHES = 40;
    localparam logic [1:0]  UNIT_RAW     = 2'd2;   // no offset
    localparam logic [1:0]  UNIT_RAW_ALT = 2'd3;   // behaves like no offset
    localparam logic [1:0]  CFG_SPARE_A  = 2'd2;   // unused index, ignored
    localparam logic [1:0]  CFG_SPARE_B  = 2'd3;   // unused index, ignored

    // one expected byte transaction
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic [8:0] held;
    } serial_byte_t;

    // shadow ring and expected byte stream
    class ring_log_scoreboard;
        logic [31:0]  shadow_log [LOG_DEPTH];
        logic [7:0]   wr_ptr;
        logic [7:0]   rd_ptr;
        logic [8:0]   held;
        logic [1:0]   unit_mode;
        logic [31:0]  interval_ms;
        serial_byte_t pending_bytes[$];
        int           failures;

        function new();
            wr_ptr      = '0;
            rd_ptr      = '0;
            held        = '0;
            unit_mode   = UNIT_RESET;
            interval_ms = INTERVAL_RESET;
            failures    = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [31:0] value);
            if (idx == CFG_UNIT_MODE)
                unit_mode = value[1:0];
            else if (idx == CFG_INTERVAL_MS)
                interval_ms = value;
        endfunction

        // queue two words as eight bytes, low byte first
        function void queue_words(logic [31:0] w0, logic [31:0] w1);
            serial_byte_t sb;
            logic [31:0]  w;
            for (int k = 0; k < 8; k++)
            begin
                w       = (k < 4) ? w0 : w1;
                sb.data = w[8 * (k % 4) +: 8];
                sb.last = (k == 7);
                sb.held = held;
                pending_bytes.push_back(sb);
            end
        endfunction

        // update the shadow ring for an accepted command
        function void apply_command(logic [1:0] c, logic [31:0] rec);
            logic [31:0] r;
            logic [31:0] temp;
            logic [31:0] total;
            case (c)
                CMD_PUSH:
                begin
                    shadow_log[wr_ptr] = rec;
                    wr_ptr             = wr_ptr + 8'd1;
                    if (held < 9'(LOG_DEPTH))
                        held = held + 9'd1;
                    else
                        rd_ptr = rd_ptr + 8'd1;   // full: oldest dropped
                end
                CMD_PULL:
                begin
                    if (held != 0)
                    begin
                        r      = shadow_log[rd_ptr];
                        rd_ptr = rd_ptr + 8'd1;
                        held   = held - 9'd1;
                        temp   = {17'd0, r[31:17]};
                        if (unit_mode == UNIT_KELVIN)
                            temp = temp + KELVIN_OFS;
                        else if (unit_mode == UNIT_CELSIUS)
                            temp = temp - CELSIUS_OFS;
                        queue_words(temp, {15'd0, r[16:0]});
                    end
                end
                CMD_CLEAR:
                begin
                    wr_ptr = '0;
                    rd_ptr = '0;
                    held   = '0;
                end
                default:
                begin
                    total = (32'(LOG_DEPTH) - {23'd0, held}) * (interval_ms / 32'd1000);
                    queue_words({23'd0, held}, total);
                end
            endcase
        endfunction

        function void check_byte(logic [7:0] b, logic last, logic [8:0] h);
            serial_byte_t want;
            if (pending_bytes.size() == 0)
            begin
                $display("%0t: unexpected byte data %h last %b held %0d",
                         $time, b, last, h);
                failures++;
                return;
            end
            want = pending_bytes.pop_front();
            if (b !== want.data)
            begin
                $display("%0t: data_byte expected %h actual %h", $time, want.data, b);
                failures++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_byte expected %b actual %b", $time, want.last, last);
                failures++;
            end
            if (h !== want.held)
            begin
                $display("%0t: records_held expected %0d actual %0d",
                         $time, want.held, h);
                failures++;
            end
        endfunction

        function int pending();
            return pending_bytes.size();
        endfunction
    endclass

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        in_valid     = 1'b0;
    logic        in_stall;
    logic [1:0]  cmd          = CMD_PUSH;
    logic [31:0] record       = '0;
    logic        out_valid;
    logic        out_stall    = 1'b0;
    logic [7:0]  data_byte;
    logic        last_byte;
    logic [8:0]  records_held;
    logic        cfg_valid    = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index    = CFG_UNIT_MODE;
    logic [31:0] cfg_data     = '0;

    bit          gaps_on      = 1'b1;
    int          cycle_count  = 0;
    ring_log_scoreboard ring_sb;

    overwriting_sample_log_ring_core uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .cmd          (cmd),
        .record       (record),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .data_byte    (data_byte),
        .last_byte    (last_byte),
        .records_held (records_held),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // random back-pressure on the byte side
    always @(negedge clk)
    begin
        out_stall <= gaps_on && ($urandom_range(0, 99) < 30);
    end

    // byte monitor
    always @(posedge clk)
    begin
        if (rst_n && out_valid === 1'b1 && out_stall === 1'b0)
            ring_sb.check_byte(data_byte, last_byte, records_held);
    end

    // one command transaction; entered and left just after a falling edge
    task automatic issue(input logic [1:0] c, input logic [31:0] r);
        while (gaps_on && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        cmd      <= c;
        record   <= r;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        ring_sb.apply_command(c, r);
        @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        ring_sb.write_reg(idx, value);
        @(negedge clk);
    endtask

    // program both registers; unit mode upper bits are noise
    task automatic program_regs(input logic [1:0] unit, input logic [31:0] interval,
                                input bit spare);
        logic [31:0] noise;
        noise = $urandom;
        cfg_write(CFG_UNIT_MODE, {noise[31:2], unit});
        cfg_write(CFG_INTERVAL_MS, interval);
        if (spare)
        begin
            cfg_write(CFG_SPARE_A, $urandom);
            cfg_write(CFG_SPARE_B, $urandom);
        end
        cfg_valid <= 1'b0;
    endtask

    // stop issuing and wait for all outstanding bytes
    task automatic settle();
        in_valid <= 1'b0;
        while (ring_sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYC) @(negedge clk);
    endtask

    // random command mix, weighted toward push and pull
    task automatic run_mixed(input int n);
        int          pick;
        logic [1:0]  c;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                c = CMD_PUSH;
            else if (pick < 80)
                c = CMD_PULL;
            else if (pick < 94)
                c = CMD_STATUS;
            else
                c = CMD_CLEAR;
            issue(c, $urandom);
        end
    endtask

    task automatic run_phase(input logic [1:0] unit, input logic [31:0] interval,
                             input bit spare, input int n);
        program_regs(unit, interval, spare);
        // temperature code extremes in this unit
        issue(CMD_PUSH, 32'h0000_0000);
        issue(CMD_PUSH, 32'hFFFF_FFFF);
        issue(CMD_PULL, $urandom);
        issue(CMD_PULL, $urandom);
        run_mixed(n);
        settle();
    endtask

    initial
    begin
        ring_sb = new();
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: empty log, field extremes, clear, reset config
        issue(CMD_PULL, $urandom);
        issue(CMD_STATUS, $urandom);
        issue(CMD_PUSH, 32'h0000_0000);
        issue(CMD_PUSH, 32'hFFFF_FFFF);
        issue(CMD_PUSH, 32'h0001_FFFF);
        issue(CMD_PUSH, 32'hFFFE_0000);
        issue(CMD_PUSH, 32'hAAAA_AAAA);
        issue(CMD_PUSH, 32'h5555_5555);
        issue(CMD_STATUS, 32'h0);
        repeat (6) issue(CMD_PULL, 32'h0);
        issue(CMD_PULL, 32'hFFFF_FFFF);
        issue(CMD_PUSH, $urandom);
        issue(CMD_PUSH, $urandom);
        issue(CMD_CLEAR, $urandom);
        issue(CMD_PULL, $urandom);
        issue(CMD_STATUS, $urandom);
        settle();

        // unit modes and interval extremes
        run_phase(UNIT_CELSIUS, 32'd0, 1'b0, MIX_ITEMS);
        run_phase(UNIT_RAW, 32'hFFFF_FFFF, 1'b0, MIX_ITEMS);
        run_phase(UNIT_RAW_ALT, 32'd999, 1'b1, MIX_ITEMS);

        // long burst with no idling and no stalls
        program_regs(UNIT_KELVIN, $urandom, 1'b0);
        gaps_on = 1'b0;
        repeat (BURST_PUSHES) issue(CMD_PUSH, $urandom);
        issue(CMD_STATUS, $urandom);
        issue(CMD_PUSH, $urandom);
        repeat (8) issue(CMD_PULL, $urandom);
        issue(CMD_STATUS, $urandom);
        issue(CMD_CLEAR, $urandom);
        issue(CMD_STATUS, $urandom);
        settle();
        gaps_on = 1'b1;

        run_phase(UNIT_KELVIN, 32'd1999, 1'b0, MIX_ITEMS);
        run_phase(UNIT_CELSIUS, $urandom, 1'b0, MIX_ITEMS);

        if (ring_sb.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
